### src/mips_integer_core_step_macros.svh
// Assertion helpers used by the core's top module.
`ifndef MIPS_INTEGER_CORE_STEP_MACROS_SVH
`define MIPS_INTEGER_CORE_STEP_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define MICS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication whose consequence is checked in the following cycle.
`define MICS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### src/mics_pkg.sv
package mics_pkg;

  typedef struct packed {
    logic        func;
    logic [31:0] instr;
    logic [31:0] load_data;
  } in_item_t;

  typedef struct packed {
    logic [31:0] fetch_pc;
    logic        mem_valid;
    logic        mem_write;
    logic [1:0]  mem_size;
    logic [31:0] mem_addr;
    logic [31:0] mem_wdata;
    logic        syscall_hit;
    logic        halted;
    logic        unsupported;
    logic [63:0] retired_count;
  } out_item_t;

  // Load kinds held while a load is outstanding.
  localparam logic [2:0] LK_LB  = 3'd0;
  localparam logic [2:0] LK_LH  = 3'd1;
  localparam logic [2:0] LK_LW  = 3'd2;
  localparam logic [2:0] LK_LBU = 3'd3;
  localparam logic [2:0] LK_LHU = 3'd4;

  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd2;

  localparam logic [5:0] OP_SPECIAL  = 6'h00;
  localparam logic [5:0] OP_REGIMM   = 6'h01;
  localparam logic [5:0] OP_J        = 6'h02;
  localparam logic [5:0] OP_JAL      = 6'h03;
  localparam logic [5:0] OP_BEQ      = 6'h04;
  localparam logic [5:0] OP_BNE      = 6'h05;
  localparam logic [5:0] OP_BLEZ     = 6'h06;
  localparam logic [5:0] OP_BGTZ     = 6'h07;
  localparam logic [5:0] OP_ADDI     = 6'h08;
  localparam logic [5:0] OP_ADDIU    = 6'h09;
  localparam logic [5:0] OP_SLTI     = 6'h0A;
  localparam logic [5:0] OP_SLTIU    = 6'h0B;
  localparam logic [5:0] OP_ANDI     = 6'h0C;
  localparam logic [5:0] OP_ORI      = 6'h0D;
  localparam logic [5:0] OP_XORI     = 6'h0E;
  localparam logic [5:0] OP_LUI      = 6'h0F;
  localparam logic [5:0] OP_SPECIAL2 = 6'h1C;
  localparam logic [5:0] OP_LB       = 6'h20;
  localparam logic [5:0] OP_LH       = 6'h21;
  localparam logic [5:0] OP_LW       = 6'h23;
  localparam logic [5:0] OP_LBU      = 6'h24;
  localparam logic [5:0] OP_LHU      = 6'h25;
  localparam logic [5:0] OP_SB       = 6'h28;
  localparam logic [5:0] OP_SH       = 6'h29;
  localparam logic [5:0] OP_SW       = 6'h2B;

  localparam logic [5:0] FN_SLL     = 6'h00;
  localparam logic [5:0] FN_SRL     = 6'h02;
  localparam logic [5:0] FN_SRA     = 6'h03;
  localparam logic [5:0] FN_SLLV    = 6'h04;
  localparam logic [5:0] FN_SRLV    = 6'h06;
  localparam logic [5:0] FN_SRAV    = 6'h07;
  localparam logic [5:0] FN_JR      = 6'h08;
  localparam logic [5:0] FN_JALR    = 6'h09;
  localparam logic [5:0] FN_SYSCALL = 6'h0C;
  localparam logic [5:0] FN_BREAK   = 6'h0D;
  localparam logic [5:0] FN_ADD     = 6'h20;
  localparam logic [5:0] FN_ADDU    = 6'h21;
  localparam logic [5:0] FN_SUB     = 6'h22;
  localparam logic [5:0] FN_SUBU    = 6'h23;
  localparam logic [5:0] FN_AND     = 6'h24;
  localparam logic [5:0] FN_OR      = 6'h25;
  localparam logic [5:0] FN_XOR     = 6'h26;
  localparam logic [5:0] FN_NOR     = 6'h27;
  localparam logic [5:0] FN_SLT     = 6'h2A;
  localparam logic [5:0] FN_SLTU    = 6'h2B;
  localparam logic [5:0] FN_CLZ     = 6'h20;
  localparam logic [5:0] FN_CLO     = 6'h21;

  localparam logic [31:0] HALT_WORD = 32'h7000_0000;

  localparam logic [4:0] RA_IDX = 5'd31;

  localparam logic [0:0] CFG_ENTRY_PC = 1'b0;

  // Register writeback request from the execute logic.
  typedef struct packed {
    logic        en;
    logic [4:0]  idx;
    logic [31:0] data;
  } rf_wr_t;

  // Architectural state other than the register file.
  typedef struct packed {
    logic [31:0] cur_pc;
    logic [31:0] following_pc;
    logic        load_pending;
    logic [4:0]  load_dest;
    logic [2:0]  load_kind;
    logic [63:0] instr_counter;
    logic        stop_flag;
  } arch_t;

  // Leading zero count over 32 bits, as a 5-level priority tree.
  function automatic logic [5:0] clz32(input logic [31:0] v);
    logic [5:0]  n;
    logic [31:0] x;
    n = 6'd0;
    x = v;
    if (x == 32'd0) begin
      n = 6'd32;
    end else begin
      if (x[31:16] == 16'd0) begin n = n + 6'd16; x = x << 16; end
      if (x[31:24] == 8'd0)  begin n = n + 6'd8;  x = x << 8;  end
      if (x[31:28] == 4'd0)  begin n = n + 6'd4;  x = x << 4;  end
      if (x[31:30] == 2'd0)  begin n = n + 6'd2;  x = x << 2;  end
      if (x[31] == 1'b0)     begin n = n + 6'd1;  end
    end
    return n;
  endfunction

endpackage

### src/mics_regfile.sv
module mics_regfile (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [4:0]            rs_idx,
  input  logic [4:0]            rt_idx,
  output logic [31:0]           rs_data,
  output logic [31:0]           rt_data,
  input  mics_pkg::rf_wr_t      wr
);
  import mics_pkg::*;

  // Flip-flop file; entry zero is never written and reads zero.
  logic [31:0] regs_r [1:31];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i < 32; i++) regs_r[i] <= 32'd0;
    end else if (wr.en && (wr.idx != 5'd0)) begin
      regs_r[wr.idx] <= wr.data;
    end
  end

  assign rs_data = (rs_idx == 5'd0) ? 32'd0 : regs_r[rs_idx];
  assign rt_data = (rt_idx == 5'd0) ? 32'd0 : regs_r[rt_idx];

endmodule

### src/mics_exec.sv
module mics_exec (
  input  mics_pkg::in_item_t    item,
  input  mics_pkg::arch_t       st,
  input  logic [31:0]           a,
  input  logic [31:0]           b,
  output mics_pkg::arch_t       st_nxt,
  output mics_pkg::rf_wr_t      wr,
  output mics_pkg::out_item_t   res
);
  import mics_pkg::*;

  logic [5:0]  op, fn;
  logic [4:0]  rt, rd, sh;
  logic [15:0] imm;
  logic [31:0] simm, pc, btgt, jtgt, addr, ldv, tgt;
  logic        taken, unsup, sys, halt;
  logic        is_ld, is_st;
  logic [2:0]  ldk;
  logic [1:0]  stsz;

  always_comb begin
    op   = item.instr[31:26];
    rt   = item.instr[20:16];
    rd   = item.instr[15:11];
    sh   = item.instr[10:6];
    fn   = item.instr[5:0];
    imm  = item.instr[15:0];
    simm = {{16{imm[15]}}, imm};
    pc   = st.cur_pc;
    btgt = pc + 32'd4 + {simm[29:0], 2'b00};
    jtgt = {pc[31:28], item.instr[25:0], 2'b00};
    addr = a + simm;

    st_nxt = st;
    wr     = '0;
    res    = '0;
    taken  = 1'b0;
    tgt    = 32'd0;
    unsup  = 1'b0;
    sys    = 1'b0;
    halt   = 1'b0;
    is_ld  = 1'b0;
    is_st  = 1'b0;
    ldk    = LK_LB;
    stsz   = SZ_BYTE;
    ldv    = item.load_data;

    if (item.func) begin
      // Load data returning for the outstanding load.
      if (st.load_pending) begin
        case (st.load_kind)
          LK_LB:   ldv = {{24{item.load_data[7]}}, item.load_data[7:0]};
          LK_LH:   ldv = {{16{item.load_data[15]}}, item.load_data[15:0]};
          LK_LBU:  ldv = {24'd0, item.load_data[7:0]};
          LK_LHU:  ldv = {16'd0, item.load_data[15:0]};
          default: ldv = item.load_data;
        endcase
        wr = '{en: 1'b1, idx: st.load_dest, data: ldv};
        st_nxt.load_pending = 1'b0;
      end
    end else if (!st.stop_flag) begin
      st_nxt.load_pending  = 1'b0;
      st_nxt.cur_pc        = st.following_pc;
      st_nxt.following_pc  = st.following_pc + 32'd4;
      st_nxt.instr_counter = st.instr_counter + 64'd1;
      wr.idx = rd;
      unique case (op)
        OP_SPECIAL: begin
          wr.en = 1'b1;
          unique case (fn)
            FN_SLL:  wr.data = b << sh;
            FN_SRL:  wr.data = b >> sh;
            FN_SRA:  wr.data = $unsigned($signed(b) >>> sh);
            FN_SLLV: wr.data = b << a[4:0];
            FN_SRLV: wr.data = b >> a[4:0];
            FN_SRAV: wr.data = $unsigned($signed(b) >>> a[4:0]);
            FN_JR:   begin wr.en = 1'b0; taken = 1'b1; tgt = a; end
            FN_JALR: begin wr.data = pc + 32'd8; taken = 1'b1; tgt = a; end
            FN_SYSCALL: begin wr.en = 1'b0; sys = 1'b1; end
            FN_BREAK:   begin wr.en = 1'b0; halt = 1'b1; end
            FN_ADD, FN_ADDU: wr.data = a + b;
            FN_SUB, FN_SUBU: wr.data = a - b;
            FN_AND:  wr.data = a & b;
            FN_OR:   wr.data = a | b;
            FN_XOR:  wr.data = a ^ b;
            FN_NOR:  wr.data = ~(a | b);
            FN_SLT:  wr.data = {31'd0, $signed(a) < $signed(b)};
            FN_SLTU: wr.data = {31'd0, a < b};
            default: begin wr.en = 1'b0; unsup = 1'b1; end
          endcase
        end
        OP_REGIMM: begin
          if ((rt == 5'd0 && a[31]) || (rt == 5'd1 && !a[31])) begin
            taken = 1'b1; tgt = btgt;
          end
        end
        OP_J:   begin taken = 1'b1; tgt = jtgt; end
        OP_JAL: begin
          wr = '{en: 1'b1, idx: RA_IDX, data: pc + 32'd8};
          taken = 1'b1; tgt = jtgt;
        end
        OP_BEQ:  begin taken = (a == b); tgt = btgt; end
        OP_BNE:  begin taken = (a != b); tgt = btgt; end
        OP_BLEZ: begin taken = a[31] || (a == 32'd0); tgt = btgt; end
        OP_BGTZ: begin taken = !a[31] && (a != 32'd0); tgt = btgt; end
        OP_ADDI, OP_ADDIU: wr = '{en: 1'b1, idx: rt, data: a + simm};
        OP_SLTI:  wr = '{en: 1'b1, idx: rt, data: {31'd0, $signed(a) < $signed(simm)}};
        OP_SLTIU: wr = '{en: 1'b1, idx: rt, data: {31'd0, a < simm}};
        OP_ANDI:  wr = '{en: 1'b1, idx: rt, data: a & {16'd0, imm}};
        OP_ORI:   wr = '{en: 1'b1, idx: rt, data: a | {16'd0, imm}};
        OP_XORI:  wr = '{en: 1'b1, idx: rt, data: a ^ {16'd0, imm}};
        OP_LUI:   wr = '{en: 1'b1, idx: rt, data: {imm, 16'd0}};
        OP_LB:  begin is_ld = 1'b1; ldk = LK_LB;  end
        OP_LH:  begin is_ld = 1'b1; ldk = LK_LH;  end
        OP_LW:  begin is_ld = 1'b1; ldk = LK_LW;  end
        OP_LBU: begin is_ld = 1'b1; ldk = LK_LBU; end
        OP_LHU: begin is_ld = 1'b1; ldk = LK_LHU; end
        OP_SB:  begin is_st = 1'b1; stsz = SZ_BYTE; end
        OP_SH:  begin is_st = 1'b1; stsz = SZ_HALF; end
        OP_SW:  begin is_st = 1'b1; stsz = SZ_WORD; end
        OP_SPECIAL2: begin
          if (item.instr == HALT_WORD) begin
            halt = 1'b1;
          end else if (fn == FN_CLZ) begin
            wr = '{en: 1'b1, idx: rd, data: {26'd0, clz32(a)}};
          end else if (fn == FN_CLO) begin
            wr = '{en: 1'b1, idx: rd, data: {26'd0, clz32(~a)}};
          end else begin
            unsup = 1'b1;
          end
        end
        default: unsup = 1'b1;
      endcase

      if (sys) st_nxt.cur_pc = pc;
      if (halt) st_nxt.stop_flag = 1'b1;
      if (taken) st_nxt.following_pc = tgt;

      if (is_ld && rt != 5'd0) begin
        st_nxt.load_pending = 1'b1;
        st_nxt.load_dest    = rt;
        st_nxt.load_kind    = ldk;
        res.mem_valid = 1'b1;
        res.mem_size  = (ldk == LK_LW) ? SZ_WORD :
                        ((ldk == LK_LH || ldk == LK_LHU) ? SZ_HALF : SZ_BYTE);
        res.mem_addr  = addr;
      end
      if (is_st) begin
        res.mem_valid = 1'b1;
        res.mem_write = 1'b1;
        res.mem_size  = stsz;
        res.mem_addr  = addr;
        res.mem_wdata = (stsz == SZ_BYTE) ? {24'd0, b[7:0]} :
                        ((stsz == SZ_HALF) ? {16'd0, b[15:0]} : b);
      end
      res.syscall_hit = sys;
      res.unsupported = unsup;
    end

    res.fetch_pc      = st_nxt.cur_pc;
    res.halted        = st_nxt.stop_flag;
    res.retired_count = st_nxt.instr_counter;
  end

endmodule

### src/mips_integer_core_step.sv
// MIPS I integer core, one instruction per item. An execute item (func 0)
// runs the word at the last fetch_pc; a deliver item (func 1) returns data
// for the outstanding load. Each accepted item gives exactly one result
// item. The register file and PC pair are read and updated in the same
// cycle the item is accepted, and the result is captured in an output
// register, so the block takes one item per clock whenever the result
// register is empty or being drained in that cycle. The register file is
// read and written back within the accepting cycle, so each item sees
// the writes of the item before it. Writing entry_pc (address 0) resets
// the PC pair to entry_pc and entry_pc plus four.
module mips_integer_core_step (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mics_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mics_pkg::out_item_t  out_data,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [1:0]           cfg_paddr,
  input  logic [31:0]          cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready
);
  import mics_pkg::*;
  `include "mips_integer_core_step_macros.svh"

  arch_t       st_r, st_nxt;
  logic [31:0] entry_pc_r;
  out_item_t   res, out_r;
  logic        out_valid_r;
  rf_wr_t      wr, wr_q;
  logic [31:0] a, b;
  logic        accept, cfg_wr;

  assign accept   = in_valid && in_ready;
  assign in_ready = !out_valid_r || out_ready;
  assign cfg_pready = 1'b1;
  assign cfg_wr   = cfg_psel && cfg_penable && cfg_pwrite;
  // Only one register exists; the lower address bit selects nothing.
  assign cfg_prdata = (cfg_paddr[1:1] == CFG_ENTRY_PC) ? entry_pc_r : 32'd0;

  assign wr_q = '{en: wr.en && accept, idx: wr.idx, data: wr.data};

  mics_regfile u_rf (
    .clk     (clk),
    .rst_n   (rst_n),
    .rs_idx  (in_data.instr[25:21]),
    .rt_idx  (in_data.instr[20:16]),
    .rs_data (a),
    .rt_data (b),
    .wr      (wr_q)
  );

  mics_exec u_exec (
    .item   (in_data),
    .st     (st_r),
    .a      (a),
    .b      (b),
    .st_nxt (st_nxt),
    .wr     (wr),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_pc_r  <= 32'd0;
      st_r        <= '{cur_pc: 32'd0, following_pc: 32'd4, default: '0};
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr && cfg_paddr[1:1] == CFG_ENTRY_PC) begin
        entry_pc_r        <= cfg_pwdata;
        st_r.cur_pc       <= cfg_pwdata;
        st_r.following_pc <= cfg_pwdata + 32'd4;
      end else if (accept) begin
        st_r <= st_nxt;
      end
      if (accept) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) out_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `MICS_ASSERT_IMP(a_no_accept_when_full, out_valid_r && !out_ready, !in_ready)
  `MICS_ASSERT_NEXT(a_result_follows, accept, out_valid_r)
  `MICS_ASSERT_NEXT(a_halt_sticky, st_r.stop_flag && !cfg_wr, st_r.stop_flag)
  `MICS_ASSERT_IMP(a_mem_only_exec, accept && in_data.func, !res.mem_valid)

endmodule

### test/mips_integer_core_step_tb.sv
// Testbench for the single-step integer core. Items are built ahead of time by an
// initial block. As each item is queued it is also run through a behavioral copy of
// the core kept in this module, so the result the block should return is known.
// The expected results are stored in order. The monitor pops the oldest one on
// every accepted result item and checks it field by field.
module mips_integer_core_step_tb;
  import mics_pkg::*;

  localparam int RUN_LIMIT = 400000;
  localparam int LONG_HOLD = 300;
  localparam logic [1:0] ENTRY_PC_ADDR = 2'(CFG_ENTRY_PC * 4);

  // SPECIAL functions that do not stop the core. SYSCALL is included, BREAK is not.
  localparam logic [5:0] SPECIAL_FNS [19] = '{
    FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV, FN_JR, FN_JALR, FN_SYSCALL,
    FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND, FN_OR, FN_XOR, FN_NOR, FN_SLT, FN_SLTU};
  localparam logic [5:0] IMM_OPS [8] = '{
    OP_ADDI, OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI, OP_LUI};
  localparam logic [5:0] LOAD_OPS [5] = '{OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU};
  localparam logic [5:0] STORE_OPS [3] = '{OP_SB, OP_SH, OP_SW};
  localparam logic [5:0] FLOW_OPS [7] = '{
    OP_REGIMM, OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  mips_integer_core_step DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  // The behavioral copy of the core state, updated as items are queued.
  logic [31:0] gpr [32];
  logic [31:0] pc_now, pc_after;
  logic        load_waiting;
  logic [4:0]  load_target;
  logic [2:0]  load_type;
  logic [63:0] retired;
  logic        is_halted;

  in_item_t  instr_feed [$];
  out_item_t core_results [$];

  logic idling_on = 1'b1;
  logic long_hold_req = 1'b0;
  int   mismatches = 0;
  int   results_seen = 0;
  int   loads_issued = 0;
  int   stores_issued = 0;
  int   cycles = 0;
  bit   finished = 0;

  function automatic void write_gpr(logic [4:0] idx, logic [31:0] v);
    if (idx != 5'd0) gpr[idx] = v;
  endfunction

  function automatic logic [31:0] count_leading_zeros(logic [31:0] v);
    int n;
    n = 0;
    while (n < 32 && v[31] == 1'b0) begin
      v = v << 1;
      n++;
    end
    return 32'(n);
  endfunction

  function automatic void core_reset();
    foreach (gpr[i]) gpr[i] = '0;
    pc_now = '0;
    pc_after = 32'd4;
    load_waiting = 1'b0;
    load_target = '0;
    load_type = LK_LB;
    retired = '0;
    is_halted = 1'b0;
  endfunction

  // Runs one item through the behavioral core and returns its result item.
  function automatic out_item_t core_step(in_item_t it);
    out_item_t r;
    logic [31:0] pc, a, b, simm, imm, btgt, jtgt, addr, tgt, w, v;
    logic [5:0] op, fn;
    logic [4:0] rs, rt, rd, sh;
    logic taken, is_ld, is_st;
    logic [2:0] kind;
    logic [1:0] sz;
    r = '0;
    if (it.func) begin
      // A deliver item writes the returned data only while a load is outstanding.
      if (load_waiting) begin
        w = it.load_data;
        case (load_type)
          LK_LB:   v = {{24{w[7]}}, w[7:0]};
          LK_LH:   v = {{16{w[15]}}, w[15:0]};
          LK_LBU:  v = {24'd0, w[7:0]};
          LK_LHU:  v = {16'd0, w[15:0]};
          default: v = w;
        endcase
        write_gpr(load_target, v);
        load_waiting = 1'b0;
      end
    end else if (!is_halted) begin
      w = it.instr;
      pc = pc_now;
      op = w[31:26];
      rs = w[25:21];
      rt = w[20:16];
      rd = w[15:11];
      sh = w[10:6];
      fn = w[5:0];
      imm = {16'd0, w[15:0]};
      simm = {{16{w[15]}}, w[15:0]};
      a = gpr[rs];
      b = gpr[rt];
      btgt = pc + 32'd4 + (simm << 2);
      jtgt = {pc[31:28], w[25:0], 2'b00};
      addr = a + simm;
      taken = 1'b0;
      tgt = '0;
      is_ld = 1'b0;
      is_st = 1'b0;
      kind = LK_LB;
      sz = SZ_BYTE;
      load_waiting = 1'b0;
      pc_now = pc_after;
      pc_after = pc_now + 32'd4;
      retired++;
      case (op)
        OP_SPECIAL: begin
          case (fn)
            FN_SLL:  write_gpr(rd, b << sh);
            FN_SRL:  write_gpr(rd, b >> sh);
            FN_SRA:  write_gpr(rd, $signed(b) >>> sh);
            FN_SLLV: write_gpr(rd, b << a[4:0]);
            FN_SRLV: write_gpr(rd, b >> a[4:0]);
            FN_SRAV: write_gpr(rd, $signed(b) >>> a[4:0]);
            FN_JR: begin taken = 1'b1; tgt = a; end
            FN_JALR: begin write_gpr(rd, pc + 32'd8); taken = 1'b1; tgt = a; end
            FN_SYSCALL: begin pc_now = pc; r.syscall_hit = 1'b1; end
            FN_BREAK: is_halted = 1'b1;
            FN_ADD, FN_ADDU: write_gpr(rd, a + b);
            FN_SUB, FN_SUBU: write_gpr(rd, a - b);
            FN_AND:  write_gpr(rd, a & b);
            FN_OR:   write_gpr(rd, a | b);
            FN_XOR:  write_gpr(rd, a ^ b);
            FN_NOR:  write_gpr(rd, ~(a | b));
            FN_SLT:  write_gpr(rd, {31'd0, $signed(a) < $signed(b)});
            FN_SLTU: write_gpr(rd, {31'd0, a < b});
            default: r.unsupported = 1'b1;
          endcase
        end
        // REGIMM with any rt other than BLTZ or BGEZ silently does nothing.
        OP_REGIMM: begin
          if ((rt == 5'd0 && a[31]) || (rt == 5'd1 && !a[31])) begin
            taken = 1'b1;
            tgt = btgt;
          end
        end
        OP_J: begin taken = 1'b1; tgt = jtgt; end
        OP_JAL: begin write_gpr(RA_IDX, pc + 32'd8); taken = 1'b1; tgt = jtgt; end
        OP_BEQ: if (a == b) begin taken = 1'b1; tgt = btgt; end
        OP_BNE: if (a != b) begin taken = 1'b1; tgt = btgt; end
        OP_BLEZ: if (a[31] || a == 32'd0) begin taken = 1'b1; tgt = btgt; end
        OP_BGTZ: if (!a[31] && a != 32'd0) begin taken = 1'b1; tgt = btgt; end
        OP_ADDI, OP_ADDIU: write_gpr(rt, a + simm);
        OP_SLTI:  write_gpr(rt, {31'd0, $signed(a) < $signed(simm)});
        OP_SLTIU: write_gpr(rt, {31'd0, a < simm});
        OP_ANDI:  write_gpr(rt, a & imm);
        OP_ORI:   write_gpr(rt, a | imm);
        OP_XORI:  write_gpr(rt, a ^ imm);
        OP_LUI:   write_gpr(rt, imm << 16);
        OP_LB:  begin is_ld = 1'b1; kind = LK_LB;  sz = SZ_BYTE; end
        OP_LH:  begin is_ld = 1'b1; kind = LK_LH;  sz = SZ_HALF; end
        OP_LW:  begin is_ld = 1'b1; kind = LK_LW;  sz = SZ_WORD; end
        OP_LBU: begin is_ld = 1'b1; kind = LK_LBU; sz = SZ_BYTE; end
        OP_LHU: begin is_ld = 1'b1; kind = LK_LHU; sz = SZ_HALF; end
        OP_SB: begin is_st = 1'b1; sz = SZ_BYTE; end
        OP_SH: begin is_st = 1'b1; sz = SZ_HALF; end
        OP_SW: begin is_st = 1'b1; sz = SZ_WORD; end
        OP_SPECIAL2: begin
          if (w == HALT_WORD) is_halted = 1'b1;
          else if (fn == FN_CLZ) write_gpr(rd, count_leading_zeros(a));
          else if (fn == FN_CLO) write_gpr(rd, count_leading_zeros(~a));
          else r.unsupported = 1'b1;
        end
        default: r.unsupported = 1'b1;
      endcase
      // A load into r0 issues no request and leaves nothing outstanding.
      if (is_ld && rt != 5'd0) begin
        load_waiting = 1'b1;
        load_target = rt;
        load_type = kind;
        r.mem_valid = 1'b1;
        r.mem_size = sz;
        r.mem_addr = addr;
      end
      if (is_st) begin
        r.mem_valid = 1'b1;
        r.mem_write = 1'b1;
        r.mem_size = sz;
        r.mem_addr = addr;
        r.mem_wdata = (sz == SZ_BYTE) ? {24'd0, b[7:0]} :
                      (sz == SZ_HALF) ? {16'd0, b[15:0]} : b;
      end
      if (taken) pc_after = tgt;
    end
    r.fetch_pc = pc_now;
    r.halted = is_halted;
    r.retired_count = retired;
    return r;
  endfunction

  // Queues one item and its expected result.
  function automatic out_item_t push_item(logic func, logic [31:0] word, logic [31:0] data);
    in_item_t it;
    out_item_t r;
    it.func = func;
    it.instr = word;
    it.load_data = data;
    r = core_step(it);
    if (r.mem_valid && !r.mem_write) loads_issued++;
    if (r.mem_valid && r.mem_write) stores_issued++;
    instr_feed.push_back(it);
    core_results.push_back(r);
    return r;
  endfunction

  function automatic void push_exec(logic [31:0] word);
    void'(push_item(1'b0, word, $urandom));
  endfunction

  function automatic void push_deliver(logic [31:0] data);
    void'(push_item(1'b1, $urandom, data));
  endfunction

  function automatic logic [31:0] r_type(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                         logic [4:0] rd, logic [4:0] sh);
    return {OP_SPECIAL, rs, rt, rd, sh, fn};
  endfunction

  function automatic logic [31:0] i_type(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                         logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  // Mostly low registers, so that instructions depend on one another.
  function automatic logic [4:0] pick_reg();
    return ($urandom_range(0, 3) != 0) ? 5'($urandom_range(0, 7)) : 5'($urandom_range(0, 31));
  endfunction

  function automatic logic [31:0] random_instr();
    int k;
    logic [31:0] w;
    k = $urandom_range(0, 99);
    w = $urandom;
    if (k < 28)
      w = r_type(SPECIAL_FNS[$urandom_range(0, 17) + (($urandom_range(0, 9) == 0) ? 1 : 0)],
                 pick_reg(), pick_reg(), pick_reg(), 5'($urandom));
    else if (k < 48)
      w = i_type(IMM_OPS[$urandom_range(0, 7)], pick_reg(), pick_reg(), 16'($urandom));
    else if (k < 64)
      w = i_type(LOAD_OPS[$urandom_range(0, 4)], pick_reg(), pick_reg(), 16'($urandom));
    else if (k < 74)
      w = i_type(STORE_OPS[$urandom_range(0, 2)], pick_reg(), pick_reg(), 16'($urandom));
    else if (k < 86) begin
      w = i_type(FLOW_OPS[$urandom_range(0, 6)], pick_reg(), pick_reg(), 16'($urandom));
      if (w[31:26] == OP_REGIMM) w[20:16] = 5'($urandom_range(0, 3));
    end else if (k < 92)
      w = {OP_SPECIAL2, pick_reg(), pick_reg(), pick_reg(), 5'($urandom),
           ($urandom_range(0, 1) != 0) ? FN_CLZ : FN_CLO};
    // Anything else is a raw random word, kept away from the two stopping encodings.
    if (w == HALT_WORD) w[0] = 1'b1;
    if (w[31:26] == OP_SPECIAL && w[5:0] == FN_BREAK) w[0] = 1'b0;
    return w;
  endfunction

  // Random instruction stream. Most loads get their data right after, some never do.
  task automatic queue_random(int count);
    out_item_t r;
    repeat (count) begin
      if ($urandom_range(0, 29) == 0) begin
        push_deliver($urandom);
      end else begin
        r = push_item(1'b0, random_instr(), $urandom);
        if (r.mem_valid && !r.mem_write && $urandom_range(0, 7) != 0) push_deliver($urandom);
      end
    end
  endtask

  task automatic wait_drained();
    wait (instr_feed.size() == 0 && core_results.size() == 0);
    repeat (5) @(posedge clk);
  endtask

  // Register write with a setup and an access phase; the register takes the value on the access-phase edge.
  task automatic cfg_write(logic [1:0] addr, logic [31:0] data);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (addr == ENTRY_PC_ADDR) begin
      pc_now = data;
      pc_after = data + 32'd4;
    end
  endtask

  // Sender side. A new item is presented only once the previous one is taken, and
  // random gaps are inserted while idling is enabled.
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (instr_feed.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= instr_feed.pop_front();
        if (idling_on && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 19);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver side. It checks every accepted result item against the oldest
  // expectation and stalls in random bursts, or for one long stretch on request.
  int stall_left = 0;
  always @(posedge clk) begin
    out_item_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (core_results.size() == 0) begin
          if (mismatches < 10) $display("Unexpected result item: %p", out_data);
          mismatches++;
        end else begin
          e = core_results.pop_front();
          if (out_data.fetch_pc !== e.fetch_pc || out_data.mem_valid !== e.mem_valid ||
              out_data.mem_write !== e.mem_write || out_data.mem_size !== e.mem_size ||
              out_data.mem_addr !== e.mem_addr || out_data.mem_wdata !== e.mem_wdata ||
              out_data.syscall_hit !== e.syscall_hit || out_data.halted !== e.halted ||
              out_data.unsupported !== e.unsupported ||
              out_data.retired_count !== e.retired_count) begin
            if (mismatches < 10) begin
              $display("Mismatch on result item %0d", results_seen);
              $display("  expected %p", e);
              $display("  actual   %p", out_data);
            end
            mismatches++;
          end
        end
      end
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (idling_on && $urandom_range(0, 11) == 0) stall_left = $urandom_range(1, 19);
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles++;
    if (cycles > RUN_LIMIT && !finished) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycles, core_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic [31:0] ld_word;
    core_reset();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // The entry point sits at the top of the address space, so the PC pair wraps.
    cfg_write(ENTRY_PC_ADDR, 32'hFFFF_FFFC);

    // Directed part. An all-ones register and a sign-bit register give the operand extremes.
    push_exec(i_type(OP_LUI, 5'd0, 5'd1, 16'hFFFF));
    push_exec(i_type(OP_ORI, 5'd1, 5'd1, 16'hFFFF));
    push_exec(i_type(OP_LUI, 5'd0, 5'd2, 16'h8000));
    push_exec({OP_SPECIAL2, 5'd1, 5'd0, 5'd3, 5'd0, FN_CLO});
    push_exec({OP_SPECIAL2, 5'd1, 5'd0, 5'd4, 5'd0, FN_CLZ});
    push_exec({OP_SPECIAL2, 5'd0, 5'd0, 5'd5, 5'd0, FN_CLZ});
    foreach (SPECIAL_FNS[i])
      push_exec(r_type(SPECIAL_FNS[i], 5'($urandom_range(1, 2)), 5'($urandom_range(1, 2)),
                       5'($urandom_range(6, 9)), 5'd31));
    foreach (IMM_OPS[i]) push_exec(i_type(IMM_OPS[i], 5'd1, 5'd10, 16'h8000));
    // Every load kind with the sign bit of its size set in the returned data.
    foreach (LOAD_OPS[i]) begin
      push_exec(i_type(LOAD_OPS[i], 5'd2, 5'd11, 16'hFFFF));
      push_deliver(32'hFFFF_8080);
    end
    foreach (STORE_OPS[i]) push_exec(i_type(STORE_OPS[i], 5'd1, 5'd1, 16'h7FFF));
    foreach (FLOW_OPS[i]) push_exec(i_type(FLOW_OPS[i], 5'd2, 5'd0, 16'h8000));
    // Load into r0, then a deliver with nothing outstanding.
    push_exec(i_type(OP_LW, 5'd1, 5'd0, 16'h0004));
    push_deliver(32'h1234_5678);
    // A load dropped by the next instruction; the late deliver must be ignored.
    push_exec(i_type(OP_LW, 5'd1, 5'd12, 16'h0000));
    push_exec(i_type(OP_ADDIU, 5'd0, 5'd13, 16'h0001));
    push_deliver(32'hDEAD_BEEF);
    push_exec(i_type(OP_REGIMM, 5'd1, 5'd17, 16'h0010));
    push_exec({6'h3F, 26'h3FF_FFFF});
    push_exec({OP_SPECIAL2, 5'd1, 5'd1, 5'd1, 5'd0, 6'h3F});
    push_exec(r_type(6'h3F, 5'd1, 5'd1, 5'd1, 5'd0));
    wait_drained();

    // Random part with a long receiver stall in the middle. The sender keeps
    // offering items, so the block fills up and stops taking input.
    cfg_write(ENTRY_PC_ADDR, 32'h0000_0000);
    queue_random(450);
    wait (instr_feed.size() < 300);
    @(negedge clk);
    long_hold_req = 1'b1;
    wait_drained();

    cfg_write(ENTRY_PC_ADDR, $urandom);
    queue_random(420);
    wait_drained();

    // Last part without idling on either side, then the core is stopped.
    cfg_write(ENTRY_PC_ADDR, 32'hFFFF_FFFF);
    @(posedge clk);
    idling_on = 1'b0;
    queue_random(350);
    ld_word = i_type(OP_LH, 5'd3, 5'd14, 16'h0002);
    push_exec(ld_word);
    push_exec(($urandom_range(0, 1) != 0) ? HALT_WORD : r_type(FN_BREAK, 5'd1, 5'd2, 5'd3, 5'd4));
    push_exec(r_type(FN_ADDU, 5'd1, 5'd1, 5'd15, 5'd0));
    push_exec(i_type(OP_LW, 5'd1, 5'd16, 16'h0000));
    push_deliver(32'h0000_8001);
    wait_drained();
    repeat (20) @(posedge clk);

    finished = 1;
    $display("Ran %0d result items from random and directed instruction streams;", results_seen);
    $display("%0d loads and %0d stores issued, %0d mismatches.", loads_issued, stores_issued,
             mismatches);
    if (mismatches == 0 && core_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/mics_pkg.sv
src/mics_regfile.sv
src/mics_exec.sv
src/mips_integer_core_step.sv
test/mips_integer_core_step_tb.sv
